// ===== hw/rtl/mhpq_pkg.sv =====
package mhpq_pkg;

	localparam int DEPTH_DEF     = 64;
	localparam int KEY_WIDTH_DEF = 32;
	localparam int OCC_WIDTH_DEF = $clog2(DEPTH_DEF + 1);

	// Index fields are sized for the largest supported heap of 4096 entries.
	localparam int IDX_MAX_W = 13;
	localparam int LVL_W     = 4;

	localparam int CAP_W = 7;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	localparam int STATUS_W = 2;
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	typedef enum logic {
		TOK_INSERT = 1'b0,
		TOK_REMOVE = 1'b1
	} tok_op_t;

	// Token moving down the chain; pos is the in-level position of the parent node.
	typedef struct packed {
		logic                 valid;
		tok_op_t              op;
		logic [IDX_MAX_W-1:0] pos;
	} tok_t;

	// Write from a cell into the level above; pos is the in-level node position there.
	typedef struct packed {
		logic                 valid;
		logic [IDX_MAX_W-1:0] pos;
	} wb_t;

	// Read of one node, used to pick up the last entry of the heap.
	typedef struct packed {
		logic                 valid;
		logic [LVL_W-1:0]     level;
		logic [IDX_MAX_W-1:0] pos;
	} fetch_t;

	function automatic logic [LVL_W-1:0] msb_index(input logic [IDX_MAX_W-1:0] v);
		logic [LVL_W-1:0] r;
		r = '0;
		for (int i = 0; i < IDX_MAX_W; i++) begin
			if (v[i]) begin
				r = LVL_W'(i);
			end
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/mhpq_if.sv =====
interface mhpq_req_if #(
	parameter int KEY_WIDTH = mhpq_pkg::KEY_WIDTH_DEF
);
	logic                        valid;
	logic                        ready;
	logic                        command;
	logic signed [KEY_WIDTH-1:0] value;

	modport source (output valid, command, value, input ready);
	modport sink (input valid, command, value, output ready);
endinterface

interface mhpq_rsp_if #(
	parameter int KEY_WIDTH = mhpq_pkg::KEY_WIDTH_DEF,
	parameter int OCC_WIDTH = mhpq_pkg::OCC_WIDTH_DEF
);
	logic                               valid;
	logic                               ready;
	logic signed [KEY_WIDTH-1:0]        removed_value;
	logic [mhpq_pkg::STATUS_W-1:0]      status;
	logic [OCC_WIDTH-1:0]               occupancy;

	modport source (output valid, removed_value, status, occupancy, input ready);
	modport sink (input valid, removed_value, status, occupancy, output ready);
endinterface

// ===== hw/rtl/mhpq_cell.sv =====
module mhpq_cell #(
	parameter int KEY_WIDTH = mhpq_pkg::KEY_WIDTH_DEF,
	parameter int DEPTH     = mhpq_pkg::DEPTH_DEF,
	parameter int LEVEL     = 1,
	parameter int CW        = mhpq_pkg::OCC_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mhpq_pkg::tok_t                tok_in,
	input  logic signed [KEY_WIDTH-1:0]   key_in,
	output mhpq_pkg::tok_t                tok_out,
	output logic signed [KEY_WIDTH-1:0]   key_out,
	input  mhpq_pkg::wb_t                 wb_in,
	input  logic signed [KEY_WIDTH-1:0]   wb_key_in,
	output mhpq_pkg::wb_t                 wb_out,
	output logic signed [KEY_WIDTH-1:0]   wb_key_out,
	input  mhpq_pkg::fetch_t              fetch,
	output logic signed [KEY_WIDTH-1:0]   fetch_key,
	input  logic [CW-1:0]                 count,
	input  logic [CW-1:0]                 path,
	input  logic [mhpq_pkg::LVL_W-1:0]    depth,
	output logic                          done
);

	localparam int IW    = mhpq_pkg::IDX_MAX_W;
	localparam int BASE  = (1 << LEVEL) - 1;
	localparam int FULLN = 1 << LEVEL;
	localparam int NODES = (FULLN < DEPTH - BASE) ? FULLN : (DEPTH - BASE);
	localparam int ROWS  = (NODES + 1) / 2;
	localparam int RAW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam bit LAST  = ((1 << (LEVEL + 1)) - 1) >= DEPTH;

	logic signed [KEY_WIDTH-1:0] mem0 [2**RAW];
	logic signed [KEY_WIDTH-1:0] mem1 [2**RAW];

	logic signed [KEY_WIDTH-1:0] rd0_q, rd1_q, key_s1;
	logic                        fsel_q;
	mhpq_pkg::tok_t              tok_s1, tok_nxt;
	logic signed [KEY_WIDTH-1:0] key_nxt;

	logic                        rd_fetch, rd_en;
	logic [RAW-1:0]              rd_addr;

	logic                        we, whalf;
	logic [RAW-1:0]              wa;
	logic signed [KEY_WIDTH-1:0] wd;
	logic                        own_we, own_half;
	logic signed [KEY_WIDTH-1:0] own_wd;

	logic [mhpq_pkg::LVL_W-1:0]  sh;
	logic [CW-1:0]               path_sh;
	logic                        b_ins, is_end;
	logic signed [KEY_WIDTH-1:0] node_ins, cb;
	logic [IW:0]                 idx0, cnt_ext;
	logic                        v0, v1, gt10, gt0x, gt1x, sel1, swap;

	assign rd_fetch = fetch.valid && (fetch.level == mhpq_pkg::LVL_W'(LEVEL));
	assign rd_en    = tok_in.valid || rd_fetch;
	assign rd_addr  = tok_in.valid ? tok_in.pos[RAW-1:0] : fetch.pos[RAW:1];

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd0_q <= mem0[rd_addr];
			rd1_q <= mem1[rd_addr];
		end
		if (we && !whalf) begin
			mem0[wa] <= wd;
		end
		if (we && whalf) begin
			mem1[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in.valid) begin
			key_s1 <= key_in;
		end
		if (rd_fetch) begin
			fsel_q <= fetch.pos[0];
		end
		if (tok_nxt.valid) begin
			key_out <= key_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1  <= '0;
			tok_out <= '0;
		end else begin
			tok_s1  <= tok_in;
			tok_out <= tok_nxt;
		end
	end

	assign fetch_key = fsel_q ? rd1_q : rd0_q;

	always_comb begin
		sh       = depth - mhpq_pkg::LVL_W'(LEVEL);
		path_sh  = path >> sh;
		b_ins    = path_sh[0];
		is_end   = (depth == mhpq_pkg::LVL_W'(LEVEL));
		node_ins = b_ins ? rd1_q : rd0_q;

		idx0    = (IW + 1)'(BASE) + {tok_s1.pos, 1'b0};
		cnt_ext = (IW + 1)'(count);
		v0      = idx0 < cnt_ext;
		v1      = (idx0 + 1'b1) < cnt_ext;
		gt10    = rd1_q > rd0_q;
		gt0x    = rd0_q > key_s1;
		gt1x    = rd1_q > key_s1;
		sel1    = v1 && gt10;
		swap    = sel1 ? gt1x : (v0 && gt0x);
		cb      = sel1 ? rd1_q : rd0_q;

		tok_nxt    = '0;
		key_nxt    = key_s1;
		own_we     = 1'b0;
		own_half   = 1'b0;
		own_wd     = key_s1;
		wb_out     = '0;
		wb_key_out = key_s1;
		done       = 1'b0;

		if (tok_s1.valid) begin
			case (tok_s1.op)
				mhpq_pkg::TOK_INSERT: begin
					own_half = b_ins;
					if (is_end) begin
						own_we = 1'b1;
						done   = 1'b1;
					end else begin
						tok_nxt.valid = 1'b1;
						tok_nxt.op    = mhpq_pkg::TOK_INSERT;
						tok_nxt.pos   = {tok_s1.pos[IW-2:0], b_ins};
						if (key_s1 > node_ins) begin
							own_we  = 1'b1;
							key_nxt = node_ins;
						end
					end
				end
				mhpq_pkg::TOK_REMOVE: begin
					wb_out.valid = 1'b1;
					wb_out.pos   = tok_s1.pos;
					if (swap) begin
						wb_key_out = cb;
						if (LAST) begin
							own_we   = 1'b1;
							own_half = sel1;
							done     = 1'b1;
						end else begin
							tok_nxt.valid = 1'b1;
							tok_nxt.op    = mhpq_pkg::TOK_REMOVE;
							tok_nxt.pos   = {tok_s1.pos[IW-2:0], sel1};
						end
					end else begin
						done = 1'b1;
					end
				end
				default: begin
					done = 1'b0;
				end
			endcase
		end

		if (wb_in.valid) begin
			we    = 1'b1;
			whalf = wb_in.pos[0];
			wa    = wb_in.pos[RAW:1];
			wd    = wb_key_in;
		end else begin
			we    = own_we;
			whalf = own_half;
			wa    = tok_s1.pos[RAW-1:0];
			wd    = own_wd;
		end
	end

endmodule

// ===== hw/rtl/max_heap_priority_queue.sv =====
// Channel  Dir   Beat contents                              Accept
// req      in    command, value                             valid && ready
// rsp      out   removed_value, status, occupancy           valid && ready
// cfg      in    capacity_limit on cfg_wr_data              cfg_wr_en
//
// One item is worked at a time; the chain has one cell per heap level below the root.
// Insert into position n walks the chain down to the level of n. Remove fetches the last
// entry, then walks it down for as many levels as it sinks; full, empty and single-entry
// items skip the chain. Each level costs a registered read of its cell memory and a write.
// Reset clears the entry count and sets capacity to 64; the store needs no clearing.
// A waiting response does not block the next beat; a stalled response holds the chain.
module max_heap_priority_queue #(
	parameter int DEPTH     = mhpq_pkg::DEPTH_DEF,
	parameter int KEY_WIDTH = mhpq_pkg::KEY_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [mhpq_pkg::CAP_W-1:0]    cfg_wr_data,
	mhpq_req_if.sink                      req,
	mhpq_rsp_if.source                    rsp
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int NLEV = CW;
	localparam int CMPW = (CW > mhpq_pkg::CAP_W) ? CW : mhpq_pkg::CAP_W;
	localparam int IW   = mhpq_pkg::IDX_MAX_W;
	localparam int LW   = mhpq_pkg::LVL_W;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_FETCH = 5'b00010,
		S_FWAIT = 5'b00100,
		S_WALK  = 5'b01000,
		S_PUSH  = 5'b10000
	} state_t;

	state_t                        state_q, state_d;
	logic [CW-1:0]                 count_q, count_d, count_inc;
	logic [mhpq_pkg::CAP_W-1:0]    cap_q;
	logic signed [KEY_WIDTH-1:0]   root_q, root_d;
	logic [CW-1:0]                 path_q, path_d;
	logic [LW-1:0]                 depth_q, depth_d;
	mhpq_pkg::tok_t                tok_r_q, tok_r_d;
	logic signed [KEY_WIDTH-1:0]   key_r_q, key_r_d;
	logic signed [KEY_WIDTH-1:0]   res_removed_q, res_removed_d;
	logic [mhpq_pkg::STATUS_W-1:0] res_status_q, res_status_d;
	logic                          out_valid_q, out_load;
	logic signed [KEY_WIDTH-1:0]   out_removed_q;
	logic [mhpq_pkg::STATUS_W-1:0] out_status_q;
	logic [CW-1:0]                 out_occ_q;

	logic                          in_fire, full, empty, chain_done;
	logic signed [KEY_WIDTH-1:0]   fetched;
	mhpq_pkg::fetch_t              fetch_s;

	mhpq_pkg::tok_t                tok_c      [NLEV-1];
	logic signed [KEY_WIDTH-1:0]   key_c      [NLEV-1];
	mhpq_pkg::wb_t                 wb_c       [1:NLEV-1];
	logic signed [KEY_WIDTH-1:0]   wb_key_c   [1:NLEV-1];
	logic signed [KEY_WIDTH-1:0]   fkey_c     [1:NLEV-1];
	logic [NLEV-1:1]               done_v;
	logic [NLEV-2:0]               tok_busy;

	assign tok_c[0] = tok_r_q;
	assign key_c[0] = key_r_q;

	for (genvar l = 1; l < NLEV; l++) begin : g_cell
		if (l == NLEV - 1) begin : g_last
			mhpq_cell #(
				.KEY_WIDTH(KEY_WIDTH),
				.DEPTH(DEPTH),
				.LEVEL(l),
				.CW(CW)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.tok_in(tok_c[l-1]),
				.key_in(key_c[l-1]),
				.tok_out(),
				.key_out(),
				.wb_in('0),
				.wb_key_in('0),
				.wb_out(wb_c[l]),
				.wb_key_out(wb_key_c[l]),
				.fetch(fetch_s),
				.fetch_key(fkey_c[l]),
				.count(count_q),
				.path(path_q),
				.depth(depth_q),
				.done(done_v[l])
			);
		end else begin : g_mid
			mhpq_cell #(
				.KEY_WIDTH(KEY_WIDTH),
				.DEPTH(DEPTH),
				.LEVEL(l),
				.CW(CW)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.tok_in(tok_c[l-1]),
				.key_in(key_c[l-1]),
				.tok_out(tok_c[l]),
				.key_out(key_c[l]),
				.wb_in(wb_c[l+1]),
				.wb_key_in(wb_key_c[l+1]),
				.wb_out(wb_c[l]),
				.wb_key_out(wb_key_c[l]),
				.fetch(fetch_s),
				.fetch_key(fkey_c[l]),
				.count(count_q),
				.path(path_q),
				.depth(depth_q),
				.done(done_v[l])
			);
		end
	end

	assign req.ready  = (state_q == S_IDLE);
	assign in_fire    = req.valid && req.ready;
	assign count_inc  = count_q + 1'b1;
	assign full       = (CMPW'(count_q) >= CMPW'(cap_q)) || (count_q >= CW'(DEPTH));
	assign empty      = (count_q == '0);
	assign chain_done = |done_v;
	assign out_load   = (state_q == S_PUSH) && (!out_valid_q || rsp.ready);

	assign fetch_s.valid = (state_q == S_FETCH);
	assign fetch_s.level = depth_q;
	assign fetch_s.pos   = IW'(path_q) ^ (IW'(1) << depth_q);

	always_comb begin
		fetched = '0;
		for (int l = 1; l < NLEV; l++) begin
			if (depth_q == LW'(l)) begin
				fetched = fkey_c[l];
			end
		end
		for (int l = 0; l < NLEV - 1; l++) begin
			tok_busy[l] = tok_c[l].valid;
		end
	end

	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		root_d        = root_q;
		path_d        = path_q;
		depth_d       = depth_q;
		tok_r_d       = '0;
		key_r_d       = key_r_q;
		res_removed_d = '0;
		res_status_d  = mhpq_pkg::ST_DONE;

		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (req.command == mhpq_pkg::CMD_INSERT) begin
						if (full) begin
							res_status_d = mhpq_pkg::ST_FULL;
							state_d      = S_PUSH;
						end else begin
							count_d = count_inc;
							path_d  = count_inc;
							depth_d = mhpq_pkg::msb_index(IW'(count_inc));
							if (empty) begin
								root_d  = req.value;
								state_d = S_PUSH;
							end else begin
								if (req.value > root_q) begin
									root_d  = req.value;
									key_r_d = root_q;
								end else begin
									key_r_d = req.value;
								end
								tok_r_d.valid = 1'b1;
								tok_r_d.op    = mhpq_pkg::TOK_INSERT;
								state_d       = S_WALK;
							end
						end
					end else begin
						if (empty) begin
							res_status_d = mhpq_pkg::ST_EMPTY;
							state_d      = S_PUSH;
						end else begin
							res_removed_d = root_q;
							count_d       = count_q - 1'b1;
							path_d        = count_q;
							depth_d       = mhpq_pkg::msb_index(IW'(count_q));
							state_d       = (count_q == CW'(1)) ? S_PUSH : S_FETCH;
						end
					end
				end
			end
			S_FETCH: begin
				state_d = S_FWAIT;
			end
			S_FWAIT: begin
				key_r_d       = fetched;
				tok_r_d.valid = 1'b1;
				tok_r_d.op    = mhpq_pkg::TOK_REMOVE;
				state_d       = S_WALK;
			end
			S_WALK: begin
				if (wb_c[1].valid) begin
					root_d = wb_key_c[1];
				end
				if (chain_done) begin
					state_d = S_PUSH;
				end
			end
			S_PUSH: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			cap_q       <= mhpq_pkg::CAP_RESET;
			tok_r_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			tok_r_q <= tok_r_d;
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		root_q  <= root_d;
		path_q  <= path_d;
		depth_q <= depth_d;
		key_r_q <= key_r_d;
		if (in_fire) begin
			res_removed_q <= res_removed_d;
			res_status_q  <= res_status_d;
		end
		if (out_load) begin
			out_removed_q <= res_removed_q;
			out_status_q  <= res_status_q;
			out_occ_q     <= count_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.removed_value = out_removed_q;
	assign rsp.status        = out_status_q;
	assign rsp.occupancy     = out_occ_q;

	// Only one token or completion may exist in the chain at any time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({done_v, tok_busy}))
		else $error("more than one operation in the cell chain");

	a_chain_only_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(chain_done || (|tok_busy)) |-> (state_q == S_WALK))
		else $error("cell chain active outside the walk state");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above store depth");

	a_rsp_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_PUSH))
		else $error("response raised without a finished item");

endmodule

// ===== verif/max_heap_priority_queue_test.sv =====
`timescale 1ns / 1ps

module max_heap_priority_queue_test;

	localparam int KEY_W = mhpq_pkg::KEY_WIDTH_DEF;
	localparam int OCC_W = mhpq_pkg::OCC_WIDTH_DEF;
	localparam int HEAP_DEPTH = mhpq_pkg::DEPTH_DEF;
	localparam int CFG_W = mhpq_pkg::CAP_W;

	typedef struct packed {
		logic signed [KEY_W-1:0]       removed_value;
		logic [mhpq_pkg::STATUS_W-1:0] status;
		logic [OCC_W-1:0]              occupancy;
	} heap_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wr_en = 1'b0;
	logic [CFG_W-1:0] cfg_wr_data = '0;

	mhpq_req_if #(.KEY_WIDTH(KEY_W)) req_ch ();
	mhpq_rsp_if #(.KEY_WIDTH(KEY_W), .OCC_WIDTH(OCC_W)) rsp_ch ();

	max_heap_priority_queue #(
		.DEPTH(HEAP_DEPTH),
		.KEY_WIDTH(KEY_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	logic signed [KEY_W-1:0] model_keys [HEAP_DEPTH];
	int                      model_count;
	logic [CFG_W-1:0]        model_capacity;

	heap_result_t pending_results [$];
	int           mismatch_count = 0;
	bit           idle_en = 1'b0;
	int           stall_left = 0;

	initial begin
		req_ch.valid = 1'b0;
		req_ch.command = mhpq_pkg::CMD_INSERT;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;
	end

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic heap_result_t heap_model_step(input logic cmd,
		input logic signed [KEY_W-1:0] key);
		heap_result_t res;
		int limit;
		int pos;
		int up;
		int child;
		logic signed [KEY_W-1:0] held;
		res = '0;
		res.status = mhpq_pkg::ST_DONE;
		limit = (model_capacity > CFG_W'(HEAP_DEPTH)) ? HEAP_DEPTH
			: int'(model_capacity);
		if (cmd == mhpq_pkg::CMD_INSERT) begin
			if (model_count >= limit) begin
				res.status = mhpq_pkg::ST_FULL;
			end else begin
				pos = model_count;
				model_keys[pos] = key;
				model_count++;
				while (pos > 0) begin
					up = (pos - 1) / 2;
					if (model_keys[pos] <= model_keys[up]) begin
						break;
					end
					held = model_keys[pos];
					model_keys[pos] = model_keys[up];
					model_keys[up] = held;
					pos = up;
				end
			end
		end else begin
			if (model_count == 0) begin
				res.status = mhpq_pkg::ST_EMPTY;
			end else begin
				res.removed_value = model_keys[0];
				model_count--;
				model_keys[0] = model_keys[model_count];
				pos = 0;
				while (2 * pos + 1 < model_count) begin
					child = 2 * pos + 1;
					if (child + 1 < model_count &&
						model_keys[child + 1] > model_keys[child]) begin
						child++;
					end
					if (model_keys[child] <= model_keys[pos]) begin
						break;
					end
					held = model_keys[pos];
					model_keys[pos] = model_keys[child];
					model_keys[child] = held;
					pos = child;
				end
			end
		end
		res.occupancy = OCC_W'(model_count);
		return res;
	endfunction

	function automatic logic signed [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 9))
			0: return {1'b0, {(KEY_W-1){1'b1}}};
			1: return {1'b1, {(KEY_W-1){1'b0}}};
			2, 3: return KEY_W'($signed($urandom_range(0, 7)) - 4);
			default: return KEY_W'($urandom);
		endcase
	endfunction

	always @(negedge clk) begin
		logic next_ready;
		next_ready = 1'b1;
		if (stall_left > 0) begin
			stall_left--;
			next_ready = 1'b0;
		end else if (idle_en && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 17) - 1;
			next_ready = 1'b0;
		end
		rsp_ch.ready = next_ready;
	end

	always @(posedge clk) begin
		heap_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: result beat with nothing expected: removed_value %0d",
					$time, rsp_ch.removed_value);
				$display("%0t: unexpected beat status %0d occupancy %0d",
					$time, rsp_ch.status, rsp_ch.occupancy);
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.removed_value !== want.removed_value) begin
					mismatch_count++;
					$display("%0t: removed_value expected %0d actual %0d",
						$time, want.removed_value, rsp_ch.removed_value);
				end
				if (rsp_ch.status !== want.status) begin
					mismatch_count++;
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, rsp_ch.status);
				end
				if (rsp_ch.occupancy !== want.occupancy) begin
					mismatch_count++;
					$display("%0t: occupancy expected %0d actual %0d",
						$time, want.occupancy, rsp_ch.occupancy);
				end
			end
		end
	end

	task automatic send_request(input logic cmd, input logic signed [KEY_W-1:0] key);
		int gap;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			req_ch.valid = 1'b0;
			gap = $urandom_range(1, 17);
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.command = cmd;
		req_ch.value = key;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
		pending_results.push_back(heap_model_step(cmd, key));
		@(negedge clk);
	endtask

	task automatic drain_results();
		req_ch.valid = 1'b0;
		while (pending_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (2) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [CFG_W-1:0] cap);
		drain_results();
		cfg_wr_en = 1'b1;
		cfg_wr_data = cap;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		model_capacity = cap;
		@(negedge clk);
	endtask

	task automatic test_key_extremes();
		write_capacity(7'd64);
		send_request(mhpq_pkg::CMD_INSERT, 32'sh7fffffff);
		send_request(mhpq_pkg::CMD_INSERT, 32'sh80000000);
		send_request(mhpq_pkg::CMD_INSERT, 32'sh00000000);
		send_request(mhpq_pkg::CMD_INSERT, -32'sd1);
		send_request(mhpq_pkg::CMD_INSERT, 32'sd1);
		send_request(mhpq_pkg::CMD_INSERT, 32'sh7fffffff);
		send_request(mhpq_pkg::CMD_INSERT, 32'sh80000000);
		repeat (8) send_request(mhpq_pkg::CMD_REMOVE, pick_key());
		drain_results();
	endtask

	task automatic test_capacity_bounds();
		write_capacity(7'd1);
		send_request(mhpq_pkg::CMD_INSERT, 32'sd5);
		send_request(mhpq_pkg::CMD_INSERT, 32'sd6);
		send_request(mhpq_pkg::CMD_REMOVE, '0);
		send_request(mhpq_pkg::CMD_REMOVE, '0);
		write_capacity(7'd0);
		send_request(mhpq_pkg::CMD_INSERT, 32'sd9);
		write_capacity(7'd4);
		send_request(mhpq_pkg::CMD_INSERT, -32'sd3);
		send_request(mhpq_pkg::CMD_INSERT, 32'sd12);
		send_request(mhpq_pkg::CMD_INSERT, 32'sd7);
		// The count now sits above the lowered capacity.
		write_capacity(7'd2);
		send_request(mhpq_pkg::CMD_INSERT, 32'sd40);
		send_request(mhpq_pkg::CMD_REMOVE, '0);
		send_request(mhpq_pkg::CMD_INSERT, 32'sd41);
		send_request(mhpq_pkg::CMD_REMOVE, '0);
		drain_results();
	endtask

	task automatic test_random_traffic();
		int phase_caps [12];
		int insert_pct;
		phase_caps = '{64, 127, 5, 1, 0, 64, 100, 0, 0, 2, 64, 127};
		phase_caps[7] = $urandom_range(1, 64);
		phase_caps[8] = $urandom_range(1, 64);
		for (int p = 0; p < 12; p++) begin
			if (p >= 10) begin
				idle_en = 1'b0;
			end
			write_capacity(CFG_W'(phase_caps[p]));
			case (p % 3)
				0: insert_pct = 80;
				1: insert_pct = 50;
				default: insert_pct = 25;
			endcase
			for (int i = 0; i < 120; i++) begin
				if ($urandom_range(1, 100) <= insert_pct) begin
					send_request(mhpq_pkg::CMD_INSERT, pick_key());
				end else begin
					send_request(mhpq_pkg::CMD_REMOVE, pick_key());
				end
			end
		end
		drain_results();
	endtask

	initial begin
		for (int i = 0; i < HEAP_DEPTH; i++) begin
			model_keys[i] = '0;
		end
		model_count = 0;
		model_capacity = mhpq_pkg::CAP_RESET;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		idle_en = 1'b1;
		test_key_extremes();
		test_capacity_bounds();
		test_random_traffic();
		repeat (30) @(negedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("max_heap_priority_queue regression: pass");
		end else begin
			$display("max_heap_priority_queue regression: fail");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("max_heap_priority_queue regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/mhpq_pkg.sv
hw/rtl/mhpq_if.sv
hw/rtl/mhpq_cell.sv
hw/rtl/max_heap_priority_queue.sv
verif/max_heap_priority_queue_test.sv
